>>> rtl/key_press_event_detector_defines.svh
// Assertion macros for the key press event detector.
// Used by kped_fsm; expects clk and rst_n to be visible where a macro is used.
`ifndef KEY_PRESS_EVENT_DETECTOR_DEFINES_SVH
`define KEY_PRESS_EVENT_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define KPED_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("kped: invariant violated");
`define KPED_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kped: same-cycle implication violated");
`define KPED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kped: next-cycle implication violated");
`else
`define KPED_ASSERT(label, cond)
`define KPED_ASSERT_SAME(label, ante, cons)
`define KPED_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/kped_pkg.sv
// Shared types, constants and the key priority encoder of the key press event detector.
// No dependencies; every other file but the assertion macro header imports this package.
package kped_pkg;

    localparam int NUM_KEYS   = 8;
    localparam int LEVEL_BITS = 8;
    localparam int PIN_KEYS   = (NUM_KEYS < LEVEL_BITS) ? NUM_KEYS : LEVEL_BITS;
    localparam int KEY_W      = 4;
    localparam int KIND_W     = 3;
    localparam int TIMER_W    = 12;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic               KEY_PIN_ACTIVE = 1'b0;
    localparam logic [TIMER_W-1:0] TIMER_MAX      = {TIMER_W{1'b1}};

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = CFG_W'(2);
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(100);
    localparam logic [CFG_W-1:0] REPEAT_RESET     = CFG_W'(20);

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_DEBOUNCE = 2'd1,
        ST_PRESSED  = 2'd2,
        ST_LONG     = 2'd3
    } kped_state_t;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE      = 3'd0,
        EV_PRESS     = 3'd1,
        EV_SHORT_REL = 3'd2,
        EV_LONG      = 3'd3,
        EV_REPEAT    = 3'd4,
        EV_LONG_REL  = 3'd5
    } kped_event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_REPEAT     = 2'd2
    } kped_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] repeat_ticks;
    } kped_cfg_t;

    typedef struct packed {
        kped_event_t      kind;
        logic [KEY_W-1:0] key;
    } kped_result_t;

    // Number of the lowest pressed key, 0 when none is down. Keys without a pin never count.
    function automatic logic [KEY_W-1:0] lowest_down_key(input logic [LEVEL_BITS-1:0] levels);
        logic [KEY_W-1:0] key;
        key = '0;
        for (int i = PIN_KEYS - 1; i >= 0; i--) begin
            if (levels[i] == KEY_PIN_ACTIVE)
            begin
                key = KEY_W'(i + 1);
            end
        end
        return key;
    endfunction

endpackage

>>> rtl/kped_sample_if.sv
// Input channel of the key press event detector: one key sample per transfer.
// Depends on kped_pkg for the field widths.
interface kped_sample_if;
    import kped_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] key_levels;
    logic                  tick;

    modport source (output valid, key_levels, tick, input ready);
    modport sink   (input valid, key_levels, tick, output ready);
endinterface

>>> rtl/kped_event_if.sv
// Output channel of the key press event detector: one event result per transfer.
// Depends on kped_pkg for the field widths.
interface kped_event_if;
    import kped_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [KEY_W-1:0]  event_key;

    modport source (output valid, event_kind, event_key, input ready);
    modport sink   (input valid, event_kind, event_key, output ready);
endinterface

>>> rtl/kped_cfg_regs.sv
// Configuration register file of the key press event detector (three timing thresholds).
// Depends on kped_pkg.
module kped_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [kped_pkg::CFG_IDX_W-1:0] index,
    input  logic [kped_pkg::CFG_W-1:0] wdata,
    output kped_pkg::kped_cfg_t        cfg
);
    import kped_pkg::*;

    kped_cfg_t cfg_reg;
    kped_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            // Writes to an unused index are dropped.
            unique case (index)
                REG_DEBOUNCE:   cfg_next.debounce_ticks   = wdata;
                REG_LONG_PRESS: cfg_next.long_press_ticks = wdata;
                REG_REPEAT:     cfg_next.repeat_ticks     = wdata;
                default:        cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            cfg_reg.repeat_ticks     <= REPEAT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/kped_fsm.sv
// Debounce / press / long-hold state machine with its saturating hold timer.
// Depends on kped_pkg and the assertion macros in key_press_event_detector_defines.svh.
`include "key_press_event_detector_defines.svh"

module kped_fsm (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [kped_pkg::LEVEL_BITS-1:0] key_levels,
    input  logic                            tick,
    input  kped_pkg::kped_cfg_t             cfg,
    output kped_pkg::kped_result_t          result
);
    import kped_pkg::*;

    kped_state_t        state_reg;
    kped_state_t        state_next;
    logic [KEY_W-1:0]   held_key_reg;
    logic [KEY_W-1:0]   held_key_next;
    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic [TIMER_W-1:0] timer_adv;
    logic [KEY_W-1:0]   key;

    always_comb
    begin
        key = lowest_down_key(key_levels);

        // The tick advances the timer first; a clear below overrides it.
        timer_adv = (tick && (timer_reg != TIMER_MAX)) ? timer_reg + TIMER_W'(1) : timer_reg;

        state_next    = state_reg;
        held_key_next = held_key_reg;
        timer_next    = timer_adv;
        result.kind   = EV_NONE;
        result.key    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (key != '0)
                begin
                    held_key_next = key;
                    timer_next    = '0;
                    state_next    = ST_DEBOUNCE;
                end
            end
            ST_DEBOUNCE:
            begin
                if (key != held_key_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (timer_adv >= cfg.debounce_ticks)
                begin
                    timer_next  = '0;
                    state_next  = ST_PRESSED;
                    result.kind = EV_PRESS;
                    result.key  = held_key_reg;
                end
            end
            ST_PRESSED:
            begin
                if (key != held_key_reg)
                begin
                    state_next  = ST_IDLE;
                    result.kind = EV_SHORT_REL;
                    result.key  = held_key_reg;
                end
                else if (timer_adv >= cfg.long_press_ticks)
                begin
                    timer_next  = '0;
                    state_next  = ST_LONG;
                    result.kind = EV_LONG;
                    result.key  = held_key_reg;
                end
            end
            ST_LONG:
            begin
                if (key != held_key_reg)
                begin
                    state_next  = ST_IDLE;
                    result.kind = EV_LONG_REL;
                    result.key  = held_key_reg;
                end
                else if (timer_adv >= cfg.repeat_ticks)
                begin
                    timer_next  = '0;
                    result.kind = EV_REPEAT;
                    result.key  = held_key_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            held_key_reg <= '0;
            timer_reg    <= '0;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            held_key_reg <= held_key_next;
            timer_reg    <= timer_next;
        end
    end

    // Outside idle a real key is always latched, so every event names a key.
    `KPED_ASSERT(a_held_key_valid, (state_reg == ST_IDLE) || (held_key_reg != '0))
    `KPED_ASSERT(a_key_iff_event, (result.kind == EV_NONE) == (result.key == '0))
    `KPED_ASSERT_NEXT(a_press_enters_pressed, step && (result.kind == EV_PRESS),
        (state_reg == ST_PRESSED) && (timer_reg == '0))
    `KPED_ASSERT_NEXT(a_idle_capture, step && (state_reg == ST_IDLE) && (key != '0),
        (state_reg == ST_DEBOUNCE) && (timer_reg == '0) && (held_key_reg == $past(key)))
    `KPED_ASSERT_SAME(a_idle_silent, (state_reg == ST_IDLE), (result.kind == EV_NONE))

endmodule

>>> rtl/key_press_event_detector.sv
// Key press event detector: top level with input register, state machine and result register.
// Depends on kped_pkg, kped_sample_if, kped_event_if, kped_cfg_regs and kped_fsm.
//
// Each transfer on the samples channel carries one sample of eight active-low key pins and
// a timer tick flag. The lowest-numbered pressed key is followed through debounce, press and
// long hold, and every sample yields exactly one transfer on the events channel: no event
// (kind 0, key 0), press, short release, long press, hold repeat or long release, each with
// the key number 1 to 8. A tick advances a 12-bit hold timer that saturates at 4095; the three
// thresholds (debounce, long press, repeat period, in ticks) are written through the
// configuration port at indices 0, 1 and 2, and writes to index 3 are ignored. Write them only
// while no sample is in flight. The block takes one sample per clock: a sample is registered
// on transfer, the state machine evaluates it in the following cycle and its event is
// registered in the result register when that register is free, which raises events valid.
// The input and output registers decouple the channels, so a new sample is taken while a
// finished event waits; throughput drops below one per clock only when the events sink stalls.
module key_press_event_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    kped_sample_if.sink                       samples,
    kped_event_if.source                      events,
    input  logic                              cfg_wr_en,
    input  logic [kped_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kped_pkg::CFG_W-1:0]        cfg_wdata
);
    import kped_pkg::*;

    // Input register holding the sample under evaluation.
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [LEVEL_BITS-1:0] in_levels_reg;
    logic                  in_tick_reg;

    // Result register feeding the events channel.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    kped_result_t          out_result_reg;

    kped_cfg_t             cfg;
    kped_result_t          result;
    logic                  out_free;
    logic                  step;
    logic                  take;

    // The result register can load when it is empty or its event is transferred now.
    assign out_free = !out_valid_reg || events.ready;
    // The state machine commits the buffered sample when its event can be stored.
    assign step     = in_valid_reg && out_free;
    // A new sample enters when the input register is empty or is being drained.
    assign take     = samples.valid && samples.ready;
    assign samples.ready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (samples.ready)
        begin
            in_valid_next = samples.valid;
        end
        if (out_free)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    kped_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    kped_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .key_levels (in_levels_reg),
        .tick       (in_tick_reg),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset; they are qualified by the valid flags.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_levels_reg <= samples.key_levels;
            in_tick_reg   <= samples.tick;
        end
        if (step)
        begin
            out_result_reg <= result;
        end
    end

    assign events.valid      = out_valid_reg;
    assign events.event_kind = out_result_reg.kind;
    assign events.event_key  = out_result_reg.key;

endmodule
